// ----- rtl/pec_pkg.sv -----
// Package for the partition entry classifier: item types, codes and the mode tables.
// No dependencies; compiled first.
package pec_pkg;

   localparam logic [1:0] CMD_BEGIN  = 2'd0;
   localparam logic [1:0] CMD_HEADER = 2'd1;
   localparam logic [1:0] CMD_ENTRY  = 2'd2;

   localparam logic [2:0] ST_CONTROL = 3'd0;
   localparam logic [2:0] ST_SKIPPED = 3'd1;
   localparam logic [2:0] ST_PART    = 3'd2;
   localparam logic [2:0] ST_ENDED   = 3'd3;
   localparam logic [2:0] ST_FULL    = 3'd4;

   localparam logic [4:0] BASE_SLOTS = 5'd15;
   localparam logic [9:0] OFFSET_MAX = 10'd1023;
   localparam logic [15:0] ID_NONE   = 16'h0000;
   localparam logic [15:0] ID_ALL    = 16'hFFFF;
   localparam logic [7:0] TYPE_DOS    = 8'h00;
   localparam logic [7:0] TYPE_EXTDOS = 8'h03;
   localparam logic [7:0] CSR_TOTAL_BLOCKS = 8'd0;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [4:0]  entry_index;
      logic [7:0]  flags;
      logic [7:0]  part_type;
      logic [31:0] start_block;
      logic [31:0] block_count;
      logic [15:0] part_id;
      logic [7:0]  attributes;
      logic [5:0]  header_count;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] out_start;
      logic [31:0] out_blocks;
      logic [1:0]  size_code;
      logic [2:0]  sector_mode;
      logic [32:0] sector_total;
      logic        write_protect;
      logic        slot_valid;
      logic [4:0]  drive_slot;
   } rsp_type;

   // Work handed from front to back: a begin clear request or a checked entry.
   typedef struct packed {
      logic        clear;      // begin item: wipe the ID store
      logic        lookup;     // entry passed all checks up to the ID lookup
      logic [2:0]  status;     // final status when no lookup is needed
      logic [15:0] part_id;
      logic        type_ok;
      logic [31:0] start_block;
      logic [31:0] block_count;
      logic [1:0]  size_code;
      logic [2:0]  sector_mode;
      logic        write_protect;
      logic        slot_valid;
      logic [4:0]  drive_slot;
   } work_type;

   function automatic logic [2:0] mode_of(input logic [1:0] size, input logic [1:0] sel);
      logic [2:0] m;
      m = 3'd0;
      if (size == 2'd1) begin
         case (sel)
            2'd0: m = 3'd2;
            2'd1: m = 3'd1;
            2'd2: m = 3'd4;
            default: m = 3'd6;
         endcase
      end else if (size == 2'd2) begin
         case (sel)
            2'd0: m = 3'd1;
            2'd1: m = 3'd0;
            2'd2: m = 3'd3;
            default: m = 3'd5;
         endcase
      end
      return m;
   endfunction

endpackage

// ----- rtl/pec_if.sv -----
// Valid/ready channel interfaces for request and response items.
// Depends on pec_pkg.
interface pec_req_if import pec_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface pec_rsp_if import pec_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/pec_front.sv -----
// Front end: sector bookkeeping and all entry checks except the ID lookup.
// Depends on pec_pkg.
module pec_front import pec_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic [31:0] total_blocks,
   input  logic        in_valid,
   output logic        in_ready,
   input  req_type     in_data,
   output logic        out_valid,
   input  logic        out_ready,
   output work_type    out_data
);
   logic [4:0] map_slots_ff, map_slots_in;
   logic [9:0] offset_ff, offset_in;
   logic [4:0] hidx_ff, hidx_in;
   logic [5:0] count_ff, count_in;
   logic       ended_ff, ended_in;
   logic       first_ff, first_in;
   work_type   w;
   logic [10:0] slot;
   logic [10:0] off_sum;
   logic [1:0]  size;
   logic        fire;

   assign in_ready  = out_ready;
   assign out_valid = in_valid;
   assign out_data  = w;
   assign fire      = in_valid && out_ready;
   assign slot      = {1'b0, offset_ff} + {6'd0, in_data.entry_index};
   assign off_sum   = {1'b0, offset_ff} + {5'd0, count_ff};
   assign size      = in_data.flags[1:0];

   always_comb begin
      map_slots_in = map_slots_ff;
      offset_in = offset_ff;
      hidx_in = hidx_ff;
      count_in = count_ff;
      ended_in = ended_ff;
      first_in = first_ff;
      w = '0;
      w.status = ST_SKIPPED;
      w.part_id = in_data.part_id;
      w.type_ok = in_data.part_type == TYPE_DOS || in_data.part_type == TYPE_EXTDOS;
      w.start_block = in_data.start_block;
      w.block_count = in_data.block_count;
      w.size_code = size - 2'd1;
      w.sector_mode = mode_of(size, in_data.flags[3:2]);
      w.write_protect = in_data.attributes[7];
      w.slot_valid = slot <= {6'd0, map_slots_ff};
      w.drive_slot = w.slot_valid ? slot[4:0] : 5'd0;
      case (in_data.cmd)
         CMD_BEGIN: begin
            w.clear = 1'b1;
            w.status = ST_CONTROL;
            map_slots_in = in_data.flags[3:0] + BASE_SLOTS;
            offset_in = '0; hidx_in = '0; count_in = '0;
            ended_in = 1'b0; first_in = 1'b1;
         end
         CMD_HEADER: begin
            w.status = ST_CONTROL;
            if (first_ff) first_in = 1'b0;
            else offset_in = off_sum[10] ? OFFSET_MAX : off_sum[9:0];
            hidx_in = in_data.entry_index;
            count_in = in_data.header_count;
            ended_in = 1'b0;
         end
         CMD_ENTRY: begin
            if (!(ended_ff || in_data.entry_index == hidx_ff
                  || {1'b0, in_data.entry_index} >= count_ff)) begin
               if (size == 2'd0) begin
                  if (!w.slot_valid) begin
                     ended_in = 1'b1;
                     w.status = ST_ENDED;
                  end
               end else if (!in_data.flags[7]
                     && in_data.start_block != 32'd0
                     && in_data.start_block < total_blocks
                     && in_data.block_count != 32'd0
                     && (total_blocks - in_data.start_block) >= in_data.block_count
                     && in_data.part_id != ID_NONE && in_data.part_id != ID_ALL) begin
                  w.lookup = 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_slots_ff <= BASE_SLOTS;
         offset_ff <= '0; hidx_ff <= '0; count_ff <= '0;
         ended_ff <= 1'b0; first_ff <= 1'b1;
      end else if (fire) begin
         map_slots_ff <= map_slots_in;
         offset_ff <= offset_in; hidx_ff <= hidx_in; count_ff <= count_in;
         ended_ff <= ended_in; first_ff <= first_in;
      end
   end
endmodule

// ----- rtl/pec_queue.sv -----
// Two-entry queue between front and back; keeps both sides stalling independently.
// Depends on pec_pkg.
module pec_queue import pec_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  work_type in_data,
   output logic     out_valid,
   input  logic     out_ready,
   output work_type out_data
);
   work_type   mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic       push, pop;

   assign in_ready  = cnt_ff != 2'd2;
   assign out_valid = cnt_ff != 2'd0;
   assign out_data  = mem_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= in_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'd2)
      else $error("queue count overflow");
   assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2 && !pop) |=> cnt_ff == 2'd2)
      else $error("queue lost an item");
endmodule

// ----- rtl/pec_back.sv -----
// Back end: seen-ID store with parallel compare, final status and output register.
// Depends on pec_pkg.
module pec_back import pec_pkg::*; #(
   parameter int MAX_IDS = 64
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  work_type in_data,
   output logic     out_valid,
   input  logic     out_ready,
   output rsp_type  out_data
);
   localparam int IW = (MAX_IDS > 1) ? $clog2(MAX_IDS) : 1;

   logic [15:0]        ids_ff [MAX_IDS];
   logic [MAX_IDS-1:0] vld_ff, vld_in;
   logic               ov_ff;
   rsp_type            rsp_ff, rsp_in;
   logic               fire, dup, full;
   logic [IW-1:0]      free_idx;
   logic               store;

   assign in_ready  = !ov_ff || out_ready;
   assign fire      = in_valid && in_ready;
   assign out_valid = ov_ff;
   assign out_data  = rsp_ff;

   always_comb begin
      dup = 1'b0;
      for (int k = 0; k < MAX_IDS; k++)
         if (vld_ff[k] && ids_ff[k] == in_data.part_id) dup = 1'b1;
      full = &vld_ff;
      free_idx = '0;
      for (int k = MAX_IDS - 1; k >= 0; k--)
         if (!vld_ff[k]) free_idx = IW'(k);
   end

   always_comb begin
      store = 1'b0;
      vld_in = vld_ff;
      rsp_in = '0;
      rsp_in.status = in_data.status;
      if (in_data.clear) begin
         vld_in = '0;
      end else if (in_data.lookup) begin
         rsp_in.status = ST_SKIPPED;
         if (!dup) begin
            if (full) begin
               rsp_in.status = ST_FULL;
            end else begin
               store = 1'b1;
               vld_in[free_idx] = 1'b1;
               if (in_data.type_ok) begin
                  rsp_in.status = ST_PART;
                  rsp_in.out_start = in_data.start_block;
                  rsp_in.out_blocks = in_data.block_count;
                  rsp_in.size_code = in_data.size_code;
                  rsp_in.sector_mode = in_data.sector_mode;
                  rsp_in.sector_total = (in_data.sector_mode >= 3'd3)
                     ? {in_data.block_count, 1'b0} : {1'b0, in_data.block_count};
                  rsp_in.write_protect = in_data.write_protect;
                  rsp_in.slot_valid = in_data.slot_valid;
                  rsp_in.drive_slot = in_data.drive_slot;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire && store) ids_ff[free_idx] <= in_data.part_id;
      if (fire) rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         ov_ff <= 1'b0;
      end else begin
         if (fire) vld_ff <= vld_in;
         if (fire) ov_ff <= 1'b1;
         else if (out_ready) ov_ff <= 1'b0;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (fire && in_data.clear) |=> vld_ff == '0)
      else $error("ID store not cleared on begin");
   assert property (@(posedge clock) disable iff (reset)
      (out_valid && !out_ready) |=> out_valid && $stable(rsp_ff))
      else $error("held response changed");
   assert property (@(posedge clock) disable iff (reset)
      (fire && store) |=> $countones(vld_ff) == $countones($past(vld_ff)) + 1)
      else $error("store did not grow by one");
endmodule

// ----- rtl/partition_entry_classifier.sv -----
// Top level of the partition entry classifier: front, queue, back and CSR.
// Depends on pec_pkg, pec_if, pec_front, pec_queue, pec_back.
//
// Channel  Dir  Handshake            Payload
// req      in   req.valid/req.ready  req_type, one table item
// rsp      out  rsp.valid/rsp.ready  rsp_type, one result per item
// csr      in   APB write, pready=1  total_blocks at address 0
//
// One item per cycle sustained while rsp does not stall; an accepted item is
// written into the queue (front is combinational into the queue), then the back
// takes it from the queue and registers the result in its output register.
// The ID lookup is a combinational parallel compare over all MAX_IDS entries.
// Synchronous active-high reset clears control state and the ID valid bits.
// Stalls on rsp back up through the output register and the two-entry queue.
module partition_entry_classifier import pec_pkg::*; #(
   parameter int MAX_IDS = 64
) (
   input  logic        clock,
   input  logic        reset,
   pec_req_if.sink     req,
   pec_rsp_if.source   rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   logic [31:0] total_ff;
   logic        fq_valid, fq_ready, qb_valid, qb_ready;
   work_type    fq_data, qb_data;

   assign csr_pready = 1'b1;
   assign csr_prdata = ({6'd0, csr_paddr} == CSR_TOTAL_BLOCKS) ? total_ff : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) total_ff <= '0;
      else if (csr_psel && csr_penable && csr_pwrite
               && {6'd0, csr_paddr} == CSR_TOTAL_BLOCKS)
         total_ff <= csr_pwdata;
   end

   pec_front u_front (
      .clock, .reset, .total_blocks(total_ff),
      .in_valid(req.valid), .in_ready(req.ready), .in_data(req.data),
      .out_valid(fq_valid), .out_ready(fq_ready), .out_data(fq_data)
   );

   pec_queue u_queue (
      .clock, .reset,
      .in_valid(fq_valid), .in_ready(fq_ready), .in_data(fq_data),
      .out_valid(qb_valid), .out_ready(qb_ready), .out_data(qb_data)
   );

   pec_back #(.MAX_IDS(MAX_IDS)) u_back (
      .clock, .reset,
      .in_valid(qb_valid), .in_ready(qb_ready), .in_data(qb_data),
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out_data(rsp.data)
   );
endmodule

// ----- verif/pec_checker.sv -----
`timescale 1ns / 1ps
// Checker for the partition entry classifier: watches the req and rsp channels,
// predicts each result from its own table state and compares. Depends on pec_pkg.
module pec_checker import pec_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  rsp_type     rsp_data,
   input  logic        cfg_we,
   input  logic [31:0] cfg_total,
   output int          fail_count,
   output int          pending
);
   rsp_type     expected_rsp[$];
   logic [31:0] total_blocks;
   logic [15:0] seen_ids[64];
   logic        seen_valid[64];
   logic [5:0]  mapping_slots;
   logic [9:0]  slot_offset;
   logic [4:0]  header_index;
   logic [5:0]  entry_count;
   logic        sector_ended;
   logic        first_sector;

   assign pending = expected_rsp.size();

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   function automatic void clear_table();
      for (int k = 0; k < 64; k++) seen_valid[k] = 1'b0;
      slot_offset = '0;
      header_index = '0;
      entry_count = '0;
      sector_ended = 1'b0;
      first_sector = 1'b1;
   endfunction

   // 0 new and stored, 1 duplicate, 2 store full
   function automatic int lookup_id(input logic [15:0] id);
      int free_k;
      free_k = -1;
      for (int k = 0; k < 64; k++) begin
         if (seen_valid[k]) begin
            if (seen_ids[k] == id) return 1;
         end else if (free_k < 0) free_k = k;
      end
      if (free_k < 0) return 2;
      seen_ids[free_k] = id;
      seen_valid[free_k] = 1'b1;
      return 0;
   endfunction

   function automatic rsp_type classify(input req_type it);
      rsp_type r;
      logic [10:0] slot;
      logic [1:0] size;
      logic [2:0] mode;
      logic [10:0] sum;
      int found;
      r = '0;
      if (it.cmd == CMD_BEGIN) begin
         clear_table();
         mapping_slots = {2'b0, it.flags[3:0]} + 6'd15;
         r.status = ST_CONTROL;
         return r;
      end
      if (it.cmd == CMD_HEADER) begin
         if (first_sector) first_sector = 1'b0;
         else begin
            sum = slot_offset + entry_count;
            slot_offset = (sum > 11'd1023) ? OFFSET_MAX : sum[9:0];
         end
         header_index = it.entry_index;
         entry_count = it.header_count;
         sector_ended = 1'b0;
         r.status = ST_CONTROL;
         return r;
      end
      r.status = ST_SKIPPED;
      if (it.cmd != CMD_ENTRY) return r;
      if (sector_ended || it.entry_index == header_index || it.entry_index >= entry_count)
         return r;
      slot = slot_offset + it.entry_index;
      size = it.flags[1:0];
      if (size == 2'd0) begin
         if (slot <= mapping_slots) return r;
         sector_ended = 1'b1;
         r.status = ST_ENDED;
         return r;
      end
      if (it.flags[7]) return r;
      if (it.start_block == 0 || it.start_block >= total_blocks) return r;
      if (it.block_count == 0 || total_blocks - it.start_block < it.block_count) return r;
      if (it.part_id == ID_NONE || it.part_id == ID_ALL) return r;
      found = lookup_id(it.part_id);
      if (found == 1) return r;
      if (found == 2) begin
         r.status = ST_FULL;
         return r;
      end
      if (it.part_type != TYPE_DOS && it.part_type != TYPE_EXTDOS) return r;
      case (size)
         2'd1: case (it.flags[3:2])
            2'd0: mode = 3'd2; 2'd1: mode = 3'd1; 2'd2: mode = 3'd4; default: mode = 3'd6;
         endcase
         2'd2: case (it.flags[3:2])
            2'd0: mode = 3'd1; 2'd1: mode = 3'd0; 2'd2: mode = 3'd3; default: mode = 3'd5;
         endcase
         default: mode = 3'd0;
      endcase
      r.status = ST_PART;
      r.out_start = it.start_block;
      r.out_blocks = it.block_count;
      r.size_code = size - 2'd1;
      r.sector_mode = mode;
      r.sector_total = (mode >= 3'd3) ? {it.block_count, 1'b0} : {1'b0, it.block_count};
      r.write_protect = it.attributes[7];
      if (slot <= mapping_slots) begin
         r.slot_valid = 1'b1;
         r.drive_slot = slot[4:0];
      end
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         total_blocks = '0;
         mapping_slots = 6'd15;
         clear_table();
         expected_rsp.delete();
         fail_count = 0;
      end else begin
         if (cfg_we) total_blocks = cfg_total;
         if (req_valid && req_ready) expected_rsp.push_back(classify(req_data));
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) report("unexpected item", rsp_data.status, 0);
            else begin
               want = expected_rsp.pop_front();
               if (rsp_data.status != want.status)
                  report("status", rsp_data.status, want.status);
               if (rsp_data.out_start != want.out_start)
                  report("out_start", rsp_data.out_start, want.out_start);
               if (rsp_data.out_blocks != want.out_blocks)
                  report("out_blocks", rsp_data.out_blocks, want.out_blocks);
               if (rsp_data.size_code != want.size_code)
                  report("size_code", rsp_data.size_code, want.size_code);
               if (rsp_data.sector_mode != want.sector_mode)
                  report("sector_mode", rsp_data.sector_mode, want.sector_mode);
               if (rsp_data.sector_total != want.sector_total)
                  report("sector_total", rsp_data.sector_total, want.sector_total);
               if (rsp_data.write_protect != want.write_protect)
                  report("write_protect", rsp_data.write_protect, want.write_protect);
               if (rsp_data.slot_valid != want.slot_valid)
                  report("slot_valid", rsp_data.slot_valid, want.slot_valid);
               if (rsp_data.drive_slot != want.drive_slot)
                  report("drive_slot", rsp_data.drive_slot, want.drive_slot);
            end
         end
      end
   end
endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench top for partition_entry_classifier: clock, reset, item stimulus,
// CSR writes and verdict. Depends on pec_pkg, pec_if, pec_checker and the RTL.
module tb_top;
   import pec_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [1:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          fail_count;
   int          pending;
   int          cycle_count = 0;
   int          send_idle_pct = 0;  // percent of cycles the sender idles
   int          recv_idle_pct = 0;  // percent of cycles the receiver stalls
   int          hold_cycles = 0;    // long receiver hold-off, counted below
   int          part_count = 0;
   logic [31:0] total_now = '0;

   pec_req_if req ();
   pec_rsp_if rsp ();

   partition_entry_classifier i_dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   pec_checker i_checker (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req.ready), .req_data(req.data),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data),
      .cfg_we(csr_psel && csr_penable && csr_pwrite && csr_pready),
      .cfg_total(csr_pwdata), .fail_count(fail_count), .pending(pending)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      req.valid = 1'b0;
      req.data = '0;
      rsp.ready = 1'b0;
   end

   // Cycle limit: ~800 items, with room for heavy stalls.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 600000) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Receiver: random stalls, or a long hold-off when hold_cycles is loaded.
   always @(posedge clock) begin
      if (reset) rsp.ready <= 1'b0;
      else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp.ready <= 1'b0;
      end else rsp.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
   end

   always @(posedge clock)
      if (rsp.valid && rsp.ready && rsp.data.status == ST_PART) part_count <= part_count + 1;

   task automatic csr_write(input logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_paddr <= CSR_TOTAL_BLOCKS[1:0];
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      total_now = value;
   endtask

   // Offers one item; valid stays high across back-to-back items.
   task automatic send_item(input req_type it);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.data <= it;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
   endtask

   // Drops valid and waits first so the checker has queued the last accepted item.
   task automatic go_idle();
      req.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   function automatic req_type mk(input logic [1:0] cmd, input logic [4:0] idx,
                                  input logic [7:0] flags, input logic [5:0] hcount);
      req_type it;
      it = '0;
      it.cmd = cmd; it.entry_index = idx; it.flags = flags; it.header_count = hcount;
      return it;
   endfunction

   // Mostly well-formed entry: in range, fresh-ish ID, DOS type.
   function automatic req_type good_entry(input logic [4:0] idx);
      req_type it;
      it = '0;
      it.cmd = CMD_ENTRY;
      it.entry_index = idx;
      it.flags = {($urandom_range(9, 0) == 0), 3'b0, 2'($urandom), 2'($urandom_range(3, 1))};
      it.part_type = ($urandom_range(5, 0) == 0) ? 8'($urandom)
                   : (($urandom & 1) ? TYPE_EXTDOS : TYPE_DOS);
      if (total_now > 2) begin
         it.start_block = $urandom_range(total_now - 1, 1);
         it.block_count = $urandom_range(total_now - it.start_block, 1);
      end else begin
         it.start_block = $urandom; it.block_count = $urandom;
      end
      it.part_id = ($urandom_range(7, 0) == 0) ? 16'($urandom) : 16'($urandom_range(90, 1));
      it.attributes = 8'($urandom);
      return it;
   endfunction

   function automatic req_type noise_item();
      req_type it;
      logic [159:0] raw;
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
      it = raw[$bits(req_type)-1:0];
      return it;
   endfunction

   // One table: begin, then a chain of sectors with random headers and entries.
   task automatic send_table(input int n_sectors);
      req_type it;
      int cnt;
      send_item(mk(CMD_BEGIN, 5'($urandom), 8'($urandom), 6'($urandom)));
      for (int s = 0; s < n_sectors; s++) begin
         cnt = ($urandom_range(9, 0) == 0) ? $urandom_range(63, 0) : $urandom_range(32, 1);
         it = mk(CMD_HEADER, 5'($urandom_range(3, 0)), 8'($urandom), 6'(cnt));
         send_item(it);
         for (int e = 0; e < 10; e++) begin
            case ($urandom_range(19, 0))
               0: send_item(noise_item());
               1, 2: begin
                  it = good_entry(5'($urandom));
                  it.flags[1:0] = 2'd0;
                  send_item(it);
               end
               default: send_item(good_entry(5'($urandom_range(31, 0))));
            endcase
         end
      end
   endtask

   task automatic random_phase(input int n_tables);
      for (int t = 0; t < n_tables; t++) send_table($urandom_range(4, 1));
   endtask

   initial begin
      req_type it;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      csr_write(32'd5000);

      // Directed: entry before any header, header chain, special cases.
      send_item(mk(CMD_ENTRY, 5'd1, 8'h01, 6'd0));
      send_item(mk(CMD_BEGIN, 5'd0, 8'h0F, 6'd0));     // 30 mapping slots
      send_item(mk(CMD_HEADER, 5'd0, 8'h00, 6'd63));   // count above 32
      send_item(mk(CMD_ENTRY, 5'd0, 8'h01, 6'd0));     // header entry itself
      for (int m = 0; m < 4; m++) begin
         it = good_entry(5'(m + 1));
         it.flags = {6'(m << 2), 2'd1}; it.part_type = TYPE_DOS; it.part_id = 16'(m + 1);
         it.start_block = 1; it.block_count = 4999;
         send_item(it);
         it.flags = {6'(m << 2), 2'd2}; it.part_id = 16'(m + 10); it.entry_index = 5'(m + 5);
         send_item(it);
      end
      it.flags = 8'h03; it.part_id = 16'd1; send_item(it);            // duplicate
      it.part_id = ID_ALL; send_item(it);
      it.part_id = ID_NONE; send_item(it);
      it.part_id = 16'd77; it.part_type = 8'hFF; send_item(it);       // bad type
      it.part_id = 16'd78; it.flags = 8'h81; it.part_type = TYPE_EXTDOS; send_item(it);
      it.flags = 8'h01; it.start_block = 5000; send_item(it);         // out of range
      it.start_block = 1; it.block_count = 5000; send_item(it);
      send_item(mk(CMD_ENTRY, 5'd9, 8'h00, 6'd0));                    // end inside slots
      send_item(mk(CMD_HEADER, 5'd31, 8'h00, 6'd32));
      send_item(mk(CMD_ENTRY, 5'd31, 8'h00, 6'd0));                   // end marker at the header's own index
      send_item(mk(CMD_ENTRY, 5'd2, 8'h01, 6'd0));                    // entry with zero start block
      send_item(mk(2'd3, 5'd31, 8'hFF, 6'd63));
      go_idle();

      // ID store fill: 70 fresh IDs with wide capacity and all-ones fields.
      csr_write(32'hFFFFFFFF);
      send_item(mk(CMD_BEGIN, 5'd0, 8'h00, 6'd0));
      for (int k = 0; k < 70; k++) begin
         if (k % 30 == 0) send_item(mk(CMD_HEADER, 5'd0, 8'h00, 6'd32));
         it = good_entry(5'(k % 30 + 1));
         it.flags = 8'h0F; it.part_type = TYPE_DOS; it.part_id = 16'(k + 100);
         it.start_block = 32'd1; it.block_count = 32'hFFFFFFFE; it.attributes = 8'hFF;
         send_item(it);
      end
      go_idle();

      csr_write(32'd0);
      send_idle_pct = 24; recv_idle_pct = 78;
      random_phase(6);
      go_idle();
      csr_write(32'd100000);
      send_idle_pct = 78; recv_idle_pct = 24;
      random_phase(7);
      go_idle();

      // Long receiver hold-off while the sender keeps offering.
      csr_write(32'd3);
      send_idle_pct = 0; recv_idle_pct = 0;
      hold_cycles = 300;
      random_phase(4);
      go_idle();
      csr_write(32'd40000);
      random_phase(7);
      req.valid <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("covered begin/header/entry items, ID store fill, %0d partitions accepted,",
               part_count);
      $display("capacities from 0 to all ones, random and long output stalls");
      if (fail_count == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end
endmodule
